### design/psw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, constants and arithmetic step functions of the sphere wrap.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned RADIUS_W   = 15;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd256;
  localparam logic REG_RADIUS = 1'b0;   // register index as seen on paddr[2]

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned SQ_N       = 17;  // root bits of a 34-bit square sum
  localparam int unsigned DV_N       = 16;  // quotient bits of the correction

  typedef struct packed {
    logic signed [2:0][16:0] d;
    logic [2:0][31:0]        prod;
    logic [33:0]             dist2;
    logic                    fold;
  } psw_work_t;

  typedef struct packed {
    psw_work_t   w;
    logic [19:0] rem;
    logic [16:0] root;
  } psw_sqrt_t;

  typedef struct packed {
    logic signed [2:0][16:0] d;
    logic                    fold;
    logic [16:0]             s;
    logic [2:0][32:0]        n;
    logic [2:0][16:0]        r;
    logic [2:0][15:0]        q;
  } psw_div_t;

  // One digit of the square root: two radicand bits in, one root bit out.
  function automatic psw_sqrt_t sqrt_step(psw_sqrt_t a, logic [1:0] pair);
    psw_sqrt_t   o;
    logic [19:0] rem;
    logic [19:0] trial;
    o     = a;
    rem   = {a.rem[17:0], pair};
    trial = {1'b0, a.root, 2'b01};
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {a.root[15:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {a.root[15:0], 1'b0};
    end
    return o;
  endfunction

  // One restoring division step for all three coordinates.
  function automatic psw_div_t div_step(psw_div_t a, int unsigned k);
    psw_div_t    o;
    logic [17:0] t;
    o = a;
    for (int c = 0; c < 3; c++) begin
      t = {a.r[c], a.n[c][k]};
      if (t >= {1'b0, a.s}) begin
        o.r[c] = 17'(t - {1'b0, a.s});
        o.q[c] = {a.q[c][14:0], 1'b1};
      end else begin
        o.r[c] = t[16:0];
        o.q[c] = {a.q[c][14:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

### design/psw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_in_if / psw_out_if
// Valid/ready channels carrying one particle request and one result.
// ----------------------------------------------------------------------------
interface psw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic signed [15:0] shift_z;
  modport source(output valid, pos_x, pos_y, pos_z, shift_x, shift_y, shift_z,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, shift_x, shift_y, shift_z,
               output ready);
endinterface

interface psw_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic signed [15:0] new_z;
  logic               was_folded;
  modport source(output valid, new_x, new_y, new_z, was_folded, input ready);
  modport sink(input valid, new_x, new_y, new_z, was_folded, output ready);
endinterface

### design/psw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_cfg
// APB register file holding the sphere radius.
// ----------------------------------------------------------------------------
module psw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psw_pkg::PADDR_W-1:0]    paddr,
  input  logic [psw_pkg::PDATA_W-1:0]    pwdata,
  output logic [psw_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output logic [psw_pkg::RADIUS_W-1:0]   radius_o
);
  import psw_pkg::*;

  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIUS);

  always_comb begin
    radius_d = radius_q;
    if (wr_en) begin
      radius_d = pwdata[RADIUS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
    end else begin
      radius_q <= radius_d;
    end
  end

  assign prdata   = (paddr[2] == REG_RADIUS) ?
                    {{(PDATA_W-RADIUS_W){1'b0}}, radius_q} : '0;
  assign radius_o = radius_q;

endmodule

### design/psw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_front
// Takes requests, forms the offset position and decides whether to fold.
// ----------------------------------------------------------------------------
module psw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  psw_in_if.sink                       in_if,
  input  logic [psw_pkg::RADIUS_W-1:0] radius_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output psw_pkg::psw_work_t           q_data_o
);
  import psw_pkg::*;

  logic                    v1_q, v2_q, v3_q;
  logic                    fen;
  logic signed [2:0][16:0] d1_q, d2_q;
  logic [2:0][15:0]        m1_q;
  logic [2:0][31:0]        sq2_q, prod2_q;
  logic [29:0]             rad2_q;
  psw_work_t               w3_q;
  logic signed [2:0][16:0] d_c;
  logic [2:0][15:0]        m_c;
  logic [33:0]             sum_c;

  assign fen         = !v3_q || !q_full_i;
  assign in_if.ready = fen;
  assign q_push_o    = v3_q && !q_full_i;
  assign q_data_o    = w3_q;

  always_comb begin
    d_c[0] = 17'(signed'(in_if.pos_x)) - 17'(signed'(in_if.shift_x));
    d_c[1] = 17'(signed'(in_if.pos_y)) - 17'(signed'(in_if.shift_y));
    d_c[2] = 17'(signed'(in_if.pos_z)) - 17'(signed'(in_if.shift_z));
    for (int c = 0; c < 3; c++) begin
      m_c[c] = d_c[c][16] ? 16'(-d_c[c]) : d_c[c][15:0];
    end
    sum_c = 34'(sq2_q[0]) + 34'(sq2_q[1]) + 34'(sq2_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (fen) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      d1_q   <= d_c;
      m1_q   <= m_c;
      d2_q   <= d1_q;
      rad2_q <= 30'(radius_i) * 30'(radius_i);
      for (int c = 0; c < 3; c++) begin
        sq2_q[c]   <= 32'(m1_q[c]) * 32'(m1_q[c]);
        prod2_q[c] <= 32'({radius_i, 1'b0}) * 32'(m1_q[c]);
      end
      w3_q.d     <= d2_q;
      w3_q.prod  <= prod2_q;
      w3_q.dist2 <= sum_c;
      w3_q.fold  <= sum_c > 34'(rad2_q);
    end
  end

endmodule

### design/psw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_fifo
// Short queue between the front and back halves.
// ----------------------------------------------------------------------------
module psw_fifo #(
  parameter int unsigned DEPTH = psw_pkg::FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  psw_pkg::psw_work_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output psw_pkg::psw_work_t data_o,
  output logic               empty_o
);
  import psw_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  psw_work_t       mem_q [DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : PW'(wp_q + 1'b1);
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : PW'(rp_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

### design/psw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_back
// Pipelined square root, pipelined divide and the final fold and saturate.
// ----------------------------------------------------------------------------
module psw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  psw_pkg::psw_work_t q_data_i,
  output logic               q_pop_o,
  psw_out_if.source          out_if
);
  import psw_pkg::*;

  logic               ben;
  logic               ent_v_q;
  psw_work_t          ent_q;
  logic [SQ_N-1:0]    sq_v_q;
  psw_sqrt_t          sq_q [SQ_N];
  logic [DV_N:0]      dv_v_q;
  psw_div_t           dv_q [DV_N+1];
  psw_sqrt_t          sq_in;
  psw_div_t           setup_c;
  logic               out_v_q;
  logic signed [2:0][15:0] res_c, res_q;
  logic               fold_q;

  assign ben     = !out_v_q || out_if.ready;
  assign q_pop_o = ben && !q_empty_i;

  always_comb begin
    sq_in      = '0;
    sq_in.w    = ent_q;
    setup_c    = '0;
    setup_c.d    = sq_q[SQ_N-1].w.d;
    setup_c.fold = sq_q[SQ_N-1].w.fold;
    setup_c.s    = sq_q[SQ_N-1].root;
    for (int c = 0; c < 3; c++) begin
      setup_c.n[c] = {1'b0, sq_q[SQ_N-1].w.prod[c]} + 33'(sq_q[SQ_N-1].root[16:1]);
      setup_c.r[c] = setup_c.n[c][32:16];
    end
  end

  // Apply the rounded correction toward the origin side to folded positions, then saturate.
  always_comb begin
    logic signed [17:0] de, qe, rv;
    for (int c = 0; c < 3; c++) begin
      de = 18'(signed'(dv_q[DV_N].d[c]));
      qe = signed'({2'b00, dv_q[DV_N].q[c]});
      if (!dv_q[DV_N].fold) begin
        rv = de;
      end else if (de < 0) begin
        rv = de + qe;
      end else begin
        rv = de - qe;
      end
      res_c[c] = sat16(rv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (ben) begin
      ent_v_q <= !q_empty_i;
      sq_v_q  <= {sq_v_q[SQ_N-2:0], ent_v_q};
      dv_v_q  <= {dv_v_q[DV_N-1:0], sq_v_q[SQ_N-1]};
      out_v_q <= dv_v_q[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      ent_q    <= q_data_i;
      sq_q[0]  <= sqrt_step(sq_in, ent_q.dist2[2*(SQ_N-1) +: 2]);
      for (int g = 1; g < SQ_N; g++) begin
        sq_q[g] <= sqrt_step(sq_q[g-1], sq_q[g-1].w.dist2[2*(SQ_N-1-g) +: 2]);
      end
      dv_q[0] <= setup_c;
      for (int j = 1; j <= DV_N; j++) begin
        dv_q[j] <= div_step(dv_q[j-1], DV_N - j);
      end
      res_q  <= res_c;
      fold_q <= dv_q[DV_N].fold;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.new_x      = res_q[0];
  assign out_if.new_y      = res_q[1];
  assign out_if.new_z      = res_q[2];
  assign out_if.was_folded = fold_q;

endmodule

### design/particle_sphere_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_sphere_wrap
// Folds a displaced particle position back through a sphere of set radius.
// ----------------------------------------------------------------------------
// Pipeline: a request passes 3 front stages, the queue, 17 root and 16 divide
// steps on its way to the result; a stalled output side holds it.
// Throughput: one request per cycle while the output side does not stall; the
// pipelined root and divide units each take a new item every unstalled cycle.
// Reset: asynchronous, active low; clears all valid flags and the queue and
// sets the radius to 1.0 (256 in Q7.8). No clearing pass is needed.
module particle_sphere_wrap #(
  parameter int unsigned FIFO_DEPTH = psw_pkg::FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psw_pkg::PADDR_W-1:0] paddr,
  input  logic [psw_pkg::PDATA_W-1:0] pwdata,
  output logic [psw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  psw_in_if.sink                      in_if,
  psw_out_if.source                   out_if
);
  import psw_pkg::*;

  logic [RADIUS_W-1:0] radius;
  logic                q_push, q_full, q_pop, q_empty;
  psw_work_t           q_wdata, q_rdata;

  // The radius register feeds the front, which squares it for the compare
  // and doubles it for the correction numerator.
  psw_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .radius_o (radius)
  );

  // Front: offset, squares, products and the fold decision.
  psw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .radius_i (radius),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // The queue lets the front keep taking requests, until the queue fills, while
  // the back half is held by a stalled consumer.
  psw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Back: square root of the distance, rounded divide, fold and saturate.
  psw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

### design/psw_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_chk
// Port-level checks of the sphere wrap, bound to the top level.
// ----------------------------------------------------------------------------
module psw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [48:0] out_data_i
);
  localparam int unsigned MAX_INFLIGHT = 64;

  logic [6:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = 7'(cnt_q + 1'b1);
    end else if (out_acc && !in_acc) begin
      cnt_d = 7'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without an outstanding request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(MAX_INFLIGHT))
    else $error("too many requests in flight");

endmodule

bind particle_sphere_wrap psw_chk u_psw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  ({out_if.new_x, out_if.new_y, out_if.new_z, out_if.was_folded})
);
